// ----- rtl/htvg_pkg.sv -----
// Shared types and constants of the heightmap terrain vertex generator.
// Used by every module of the block; depends on nothing else.
package htvg_pkg;

	// Column and row fields of a queued vertex request, wide enough for the
	// largest grid the block can be built for.
	localparam int CNT_W = 11;

	// Shared divider: numerator, divisor and quotient widths.
	localparam int NUM_W = 38;
	localparam int DEN_W = 24;
	localparam int QUO_W = 17;

	// Normal length datapath.
	localparam int DXM_W = 22;
	localparam int SQ_W  = 46;
	localparam int LEN_W = 23;

	// Configuration register indexes.
	localparam logic [1:0] REG_GRID   = 2'd0;
	localparam logic [1:0] REG_HSCALE = 2'd1;
	localparam logic [1:0] REG_SIZE_X = 2'd2;
	localparam logic [1:0] REG_SIZE_Z = 2'd3;

	// One vertex request handed from the front to the back.
	typedef struct packed {
		logic [CNT_W-1:0] col;
		logic [CNT_W-1:0] row;
		logic signed [15:0] h;
		logic signed [15:0] hl;
		logic signed [15:0] hr;
		logic signed [15:0] hd;
		logic signed [15:0] hu;
	} job_t;

	typedef enum logic {
		F_IDLE,
		F_EXEC
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL,
		B_RND,
		B_SQ,
		B_SUM,
		B_SQRT,
		B_DIV_GO,
		B_DIV_WAIT,
		B_OUT
	} back_state_t;

	typedef enum logic [2:0] {
		DV_NX,
		DV_NY,
		DV_NZ,
		DV_PX,
		DV_PZ,
		DV_TU,
		DV_TV
	} div_sel_t;

endpackage

// ----- rtl/htvg_front.sv -----
// Front end: accepts samples and flush requests, keeps the two line buffers
// and the grid counters, and queues one vertex request per emitting item.
// Depends on htvg_pkg.
module htvg_front #(
	parameter int MAX_SEGMENTS = 256,
	localparam int CW = $clog2(MAX_SEGMENTS + 2)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic [CW-1:0]        segs,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic                 action,
	input  logic signed [15:0]   height_sample,
	output logic                 push,
	output htvg_pkg::job_t       job,
	input  logic                 full
);
	import htvg_pkg::*;

	localparam int DEPTH = MAX_SEGMENTS + 1;
	localparam int AW    = $clog2(MAX_SEGMENTS + 1);

	logic [15:0] prev_mem [DEPTH];
	logic [15:0] older_mem [DEPTH];

	front_state_t state_q, state_d;
	logic [CW-1:0] col_q, row_q, fcol_q, c_q;
	logic          flush_q, emit_q;
	logic [15:0]   sample_q;
	logic [15:0]   prev_c_q, prev_n_q, older_p_q, older_c_q;

	logic          accept, active, commit;
	logic [CW-1:0] cur_c, c_dec;
	logic [CW:0]   c_inc;

	assign sample_stall = (state_q != F_IDLE);
	assign accept = sample_valid && (state_q == F_IDLE);
	assign cur_c  = action ? fcol_q : col_q;
	assign active = action ? (row_q > segs) : (row_q <= segs);
	assign c_inc  = {1'b0, cur_c} + 1'b1;
	assign c_dec  = cur_c - 1'b1;
	assign commit = (state_q == F_EXEC) && (!emit_q || !full);
	assign push   = commit && emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept && active) state_d = F_EXEC;
			end
			F_EXEC: begin
				if (commit) state_d = F_IDLE;
			end
		endcase
	end

	// Line buffers: neighbours are read in the accept cycle, the buffers are
	// updated when the request leaves for the queue.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE) begin
			prev_c_q  <= prev_mem[cur_c[AW-1:0]];
			prev_n_q  <= prev_mem[c_inc[AW-1:0]];
			older_p_q <= older_mem[c_dec[AW-1:0]];
			older_c_q <= older_mem[cur_c[AW-1:0]];
		end
		if (commit) begin
			older_mem[c_q[AW-1:0]] <= prev_c_q;
			if (!flush_q) prev_mem[c_q[AW-1:0]] <= sample_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q      <= cur_c;
			flush_q  <= action;
			sample_q <= height_sample;
			emit_q   <= action || (row_q != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fcol_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			fcol_q <= '0;
		end else if (commit) begin
			if (flush_q) begin
				if (c_q >= segs) begin
					col_q  <= '0;
					row_q  <= '0;
					fcol_q <= '0;
				end else begin
					fcol_q <= fcol_q + 1'b1;
				end
			end else if (col_q >= segs) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_comb begin
		job.col = CNT_W'(c_q);
		job.row = flush_q ? CNT_W'(segs) : CNT_W'(row_q - 1'b1);
		job.h   = prev_c_q;
		job.hl  = (c_q != '0) ? older_p_q : 16'sd0;
		job.hr  = (c_q < segs) ? prev_n_q : 16'sd0;
		job.hd  = (flush_q || (row_q >= CW'(2))) ? older_c_q : 16'sd0;
		job.hu  = flush_q ? 16'sd0 : sample_q;
	end

endmodule

// ----- rtl/htvg_queue.sv -----
// Two-entry request queue between the front and the back end.
// Depends on htvg_pkg for the request type.
module htvg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  htvg_pkg::job_t din,
	output logic           full,
	input  logic           pop,
	output htvg_pkg::job_t dout,
	output logic           empty
);
	import htvg_pkg::*;

	job_t       slots_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/htvg_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all quotients
// of a vertex. The caller guarantees num < den * 2^QUO_W. Depends on htvg_pkg.
module htvg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [htvg_pkg::NUM_W-1:0]    num,
	input  logic [htvg_pkg::DEN_W-1:0]    den,
	output logic                          done,
	output logic [htvg_pkg::QUO_W-1:0]    quo
);
	import htvg_pkg::*;

	localparam int CNT_BITS = $clog2(QUO_W + 1);

	logic [DEN_W-1:0]    rem_q, den_q;
	logic [QUO_W-1:0]    low_q, quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q, busy, fits;
	logic [DEN_W:0]      trial, diff;

	assign busy  = (cnt_q != '0);
	assign trial = {rem_q, low_q[QUO_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_BITS'(1));
			if (start) cnt_q <= CNT_BITS'(QUO_W);
			else if (busy) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num[NUM_W-1:QUO_W]);
			low_q <= num[QUO_W-1:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q <= low_q << 1;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

endmodule

// ----- rtl/htvg_back.sv -----
// Back end: turns one queued request into a finished vertex through a
// sequencer (products, normal length by bit-pair square root, seven
// quotients on the shared divider) and holds it in the output register.
// Depends on htvg_pkg and htvg_div.
module htvg_back #(
	parameter int MAX_SEGMENTS = 256,
	localparam int CW = $clog2(MAX_SEGMENTS + 2)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CW-1:0]        segs,
	input  logic [15:0]          hscale,
	input  logic [14:0]          size_x,
	input  logic [14:0]          size_z,
	input  htvg_pkg::job_t       job,
	input  logic                 empty,
	output logic                 pop,
	output logic                 vertex_valid,
	input  logic                 vertex_stall,
	output logic signed [14:0]   pos_x,
	output logic signed [15:0]   pos_y,
	output logic signed [14:0]   pos_z,
	output logic signed [15:0]   norm_x,
	output logic [14:0]          norm_y,
	output logic signed [15:0]   norm_z,
	output logic [31:0]          vertex_color,
	output logic [16:0]          tex_u,
	output logic [16:0]          tex_v,
	output logic                 last_vertex
);
	import htvg_pkg::*;

	localparam logic [SQ_W-1:0]  DY_SQ    = SQ_W'(67108864);
	localparam logic [SQ_W-1:0]  SQ_TOP   = SQ_W'(1) << (SQ_W - 2);
	localparam logic [NUM_W-1:0] NY_NUM   = NUM_W'(134217728);
	localparam logic [16:0]      PY_LIMIT = 17'd25600;
	localparam logic [QUO_W-1:0] XZ_LIMIT = QUO_W'(16000);

	back_state_t state_q, state_d;
	div_sel_t    sel_q, sel_d;
	job_t        job_q;

	logic signed [33:0] pdx_q, pdz_q;
	logic signed [32:0] phy_q;
	logic [CW+15:0]     ppx_q, ppz_q;
	logic               pxn_q, pzn_q;
	logic [23:0]        colour_q;
	logic [DXM_W-1:0]   dxm_q, dzm_q;
	logic               dxn_q, dzn_q;
	logic signed [15:0] py_q;
	logic [2*DXM_W-1:0] dxx_q, dzz_q;
	logic [SQ_W-1:0]    sq_v_q, sq_res_q, sq_bit_q;
	logic [QUO_W-1:0]   nx_q, ny_q, nz_q, qx_q, qz_q, tu_q, tv_q;
	logic               vertex_valid_q;

	logic [CW-1:0]      col_c, row_c;
	logic signed [16:0] diff_x, diff_z, sc_s;
	logic signed [33:0] pdx_c, pdz_c;
	logic signed [32:0] phy_c;
	logic [CW:0]        segs_e, two_c, two_r, pxm, pzm;
	logic [CW+15:0]     ppx_c, ppz_c;
	logic signed [16:0] hn;
	logic [13:0]        n;
	logic [21:0]        r_t;
	logic [19:0]        g_t;
	logic [18:0]        b_t;
	logic [7:0]         red, grn, blu;
	logic [33:0]        mx, mz;
	logic [33:0]        rx, rz;
	logic [32:0]        my, ry;
	logic [16:0]        pym, pyc;
	logic [SQ_W-1:0]    sq_trial;
	logic [LEN_W-1:0]   len;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic               div_start, div_done, out_load;
	logic [QUO_W-1:0]   div_quo, qxc, qzc;

	assign col_c  = job_q.col[CW-1:0];
	assign row_c  = job_q.row[CW-1:0];
	assign sc_s   = $signed({1'b0, hscale});
	assign diff_x = $signed({job_q.hl[15], job_q.hl}) - $signed({job_q.hr[15], job_q.hr});
	assign diff_z = $signed({job_q.hd[15], job_q.hd}) - $signed({job_q.hu[15], job_q.hu});
	assign pdx_c  = diff_x * sc_s;
	assign pdz_c  = diff_z * sc_s;
	assign phy_c  = job_q.h * sc_s;

	assign segs_e = {1'b0, segs};
	assign two_c  = {col_c, 1'b0};
	assign two_r  = {row_c, 1'b0};
	assign pxm    = (two_c < segs_e) ? segs_e - two_c : two_c - segs_e;
	assign pzm    = (two_r < segs_e) ? segs_e - two_r : two_r - segs_e;
	assign ppx_c  = pxm * size_x;
	assign ppz_c  = pzm * size_z;

	// Height ramp: the raw sample relative to one unit either side of zero.
	always_comb begin
		hn = $signed({job_q.h[15], job_q.h}) + 17'sd4096;
		if (hn < 17'sd0) n = 14'd0;
		else if (hn > 17'sd8192) n = 14'd8192;
		else n = hn[13:0];
		r_t = n * 8'd150;
		g_t = n * 7'd100;
		b_t = n * 6'd50;
		red = 8'd50 + r_t[20:13];
		grn = 8'd100 + {1'b0, g_t[19:13]};
		blu = 8'd30 + {2'b0, b_t[18:13]};
	end

	// Rounding half away from zero of the slope and height products.
	always_comb begin
		mx  = pdx_q[33] ? 34'(-pdx_q) : 34'(pdx_q);
		mz  = pdz_q[33] ? 34'(-pdz_q) : 34'(pdz_q);
		my  = phy_q[32] ? 33'(-phy_q) : 33'(phy_q);
		rx  = mx + 34'd512;
		rz  = mz + 34'd512;
		ry  = my + 33'd32768;
		pym = ry[32:16];
		pyc = (pym > PY_LIMIT) ? PY_LIMIT : pym;
	end

	assign sq_trial = sq_res_q + sq_bit_q;
	assign len      = sq_res_q[LEN_W-1:0];

	always_comb begin
		div_num = '0;
		div_den = DEN_W'(len);
		unique case (sel_q)
			DV_NX: div_num = NUM_W'({dxm_q, 14'b0}) + NUM_W'(len >> 1);
			DV_NY: div_num = NY_NUM + NUM_W'(len >> 1);
			DV_NZ: div_num = NUM_W'({dzm_q, 14'b0}) + NUM_W'(len >> 1);
			DV_PX: begin
				div_num = NUM_W'(ppx_q) + NUM_W'(segs);
				div_den = DEN_W'({segs, 1'b0});
			end
			DV_PZ: begin
				div_num = NUM_W'(ppz_q) + NUM_W'(segs);
				div_den = DEN_W'({segs, 1'b0});
			end
			DV_TU: begin
				div_num = NUM_W'({col_c, 16'b0}) + NUM_W'(segs >> 1);
				div_den = DEN_W'(segs);
			end
			DV_TV: begin
				div_num = NUM_W'({row_c, 16'b0}) + NUM_W'(segs >> 1);
				div_den = DEN_W'(segs);
			end
			default: div_num = '0;
		endcase
	end

	htvg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			sel_q   <= DV_NX;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		sel_d     = sel_q;
		pop       = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = B_MUL;
				end
			end
			B_MUL: state_d = B_RND;
			B_RND: state_d = B_SQ;
			B_SQ:  state_d = B_SUM;
			B_SUM: state_d = B_SQRT;
			B_SQRT: begin
				if (sq_bit_q[0]) begin
					state_d = B_DIV_GO;
					sel_d   = DV_NX;
				end
			end
			B_DIV_GO: begin
				div_start = 1'b1;
				state_d   = B_DIV_WAIT;
			end
			B_DIV_WAIT: begin
				if (div_done) begin
					state_d = B_DIV_GO;
					unique case (sel_q)
						DV_NX:   sel_d = DV_NY;
						DV_NY:   sel_d = DV_NZ;
						DV_NZ:   sel_d = DV_PX;
						DV_PX:   sel_d = DV_PZ;
						DV_PZ:   sel_d = DV_TU;
						DV_TU:   sel_d = DV_TV;
						default: state_d = B_OUT;
					endcase
				end
			end
			B_OUT: begin
				if (!vertex_valid_q || !vertex_stall) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= job;
		unique case (state_q)
			B_MUL: begin
				pdx_q    <= pdx_c;
				pdz_q    <= pdz_c;
				phy_q    <= phy_c;
				ppx_q    <= ppx_c;
				ppz_q    <= ppz_c;
				pxn_q    <= (two_c < segs_e);
				pzn_q    <= (two_r < segs_e);
				colour_q <= {blu, grn, red};
			end
			B_RND: begin
				dxm_q <= rx[DXM_W+9:10];
				dzm_q <= rz[DXM_W+9:10];
				dxn_q <= pdx_q[33];
				dzn_q <= pdz_q[33];
				py_q  <= phy_q[32] ? -$signed({1'b0, pyc[14:0]}) : $signed({1'b0, pyc[14:0]});
			end
			B_SQ: begin
				dxx_q <= dxm_q * dxm_q;
				dzz_q <= dzm_q * dzm_q;
			end
			B_SUM: begin
				sq_v_q   <= SQ_W'(dxx_q) + SQ_W'(dzz_q) + DY_SQ;
				sq_res_q <= '0;
				sq_bit_q <= SQ_TOP;
			end
			B_SQRT: begin
				if (sq_v_q >= sq_trial) begin
					sq_v_q   <= sq_v_q - sq_trial;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			B_DIV_WAIT: begin
				if (div_done) begin
					unique case (sel_q)
						DV_NX:   nx_q <= div_quo;
						DV_NY:   ny_q <= div_quo;
						DV_NZ:   nz_q <= div_quo;
						DV_PX:   qx_q <= div_quo;
						DV_PZ:   qz_q <= div_quo;
						DV_TU:   tu_q <= div_quo;
						default: tv_q <= div_quo;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	assign qxc = (qx_q > XZ_LIMIT) ? XZ_LIMIT : qx_q;
	assign qzc = (qz_q > XZ_LIMIT) ? XZ_LIMIT : qz_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_x        <= pxn_q ? -$signed({1'b0, qxc[13:0]}) : $signed({1'b0, qxc[13:0]});
			pos_z        <= pzn_q ? -$signed({1'b0, qzc[13:0]}) : $signed({1'b0, qzc[13:0]});
			pos_y        <= py_q;
			norm_x       <= dxn_q ? -$signed(nx_q[15:0]) : $signed(nx_q[15:0]);
			norm_y       <= ny_q[14:0];
			norm_z       <= dzn_q ? -$signed(nz_q[15:0]) : $signed(nz_q[15:0]);
			vertex_color <= {8'hff, colour_q};
			tex_u        <= tu_q;
			tex_v        <= tv_q;
			last_vertex  <= (col_c == segs) && (row_c == segs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_valid_q <= 1'b0;
		end else if (out_load) begin
			vertex_valid_q <= 1'b1;
		end else if (!vertex_stall) begin
			vertex_valid_q <= 1'b0;
		end
	end

	assign vertex_valid = vertex_valid_q;

endmodule

// ----- rtl/heightmap_terrain_vertex_gen_core.sv -----
// Top level of the heightmap terrain vertex generator: configuration
// registers, front end, request queue and back end.
// Depends on htvg_pkg, htvg_front, htvg_queue and htvg_back.
//
//  channel   direction  handshake                 payload
//  sample    in         sample_valid/sample_stall action, height_sample
//  vertex    out        vertex_valid/vertex_stall pos, norm, color, tex, last
//  cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// The front takes one item only after the last has committed, and waits while
// the queue is full. The back does one vertex at a time: a 23-step square root
// for the normal length, seven 17-step quotients on the one shared divider.
// Reset clears counters, queue and output valid; line buffers are not cleared.
// A stalled vertex holds in the output register while the front keeps
// filling the two-entry queue.
module heightmap_terrain_vertex_gen_core #(
	parameter int MAX_SEGMENTS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic                 action,
	input  logic signed [15:0]   height_sample,
	output logic                 vertex_valid,
	input  logic                 vertex_stall,
	output logic signed [14:0]   pos_x,
	output logic signed [15:0]   pos_y,
	output logic signed [14:0]   pos_z,
	output logic signed [15:0]   norm_x,
	output logic [14:0]          norm_y,
	output logic signed [15:0]   norm_z,
	output logic [31:0]          vertex_color,
	output logic [16:0]          tex_u,
	output logic [16:0]          tex_v,
	output logic                 last_vertex,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import htvg_pkg::*;

	localparam int CW = $clog2(MAX_SEGMENTS + 2);
	localparam logic [CW-1:0] SEG_MAX = CW'(MAX_SEGMENTS);

	logic [8:0]    grid_q;
	logic [15:0]   hscale_q;
	logic [14:0]   size_x_q, size_z_q;
	logic          cfg_wr, restart;
	logic [CW-1:0] segs;
	logic          push, full, pop, empty;
	job_t          front_job, queue_job;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && (cfg_index == REG_GRID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q   <= 9'd64;
			hscale_q <= 16'd8192;
			size_x_q <= 15'd12800;
			size_z_q <= 15'd12800;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_GRID:   grid_q   <= cfg_data[8:0];
				REG_HSCALE: hscale_q <= cfg_data;
				REG_SIZE_X: size_x_q <= cfg_data[14:0];
				REG_SIZE_Z: size_z_q <= cfg_data[14:0];
			endcase
		end
	end

	// Segment count as used by the grid, held to the supported range.
	always_comb begin
		if (grid_q < 9'd8) segs = CW'(8);
		else if (32'(grid_q) > MAX_SEGMENTS) segs = SEG_MAX;
		else segs = CW'(grid_q);
	end

	htvg_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.segs          (segs),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.action        (action),
		.height_sample (height_sample),
		.push          (push),
		.job           (front_job),
		.full          (full)
	);

	htvg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_job),
		.full   (full),
		.pop    (pop),
		.dout   (queue_job),
		.empty  (empty)
	);

	htvg_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.segs         (segs),
		.hscale       (hscale_q),
		.size_x       (size_x_q),
		.size_z       (size_z_q),
		.job          (queue_job),
		.empty        (empty),
		.pop          (pop),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.norm_x       (norm_x),
		.norm_y       (norm_y),
		.norm_z       (norm_z),
		.vertex_color (vertex_color),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.last_vertex  (last_vertex)
	);

endmodule

// ----- bench/tb_heightmap_terrain_vertex_gen_core.sv -----
`timescale 1ns / 100ps
// Testbench of heightmap_terrain_vertex_gen_core: streams heightmap grids with
// random stalls and checks every vertex against an in-bench mesh predictor.
// Depends on htvg_pkg and the RTL of the block.
module tb_heightmap_terrain_vertex_gen_core;
	import htvg_pkg::*;

	localparam int SEG_MAX = 256;

	typedef struct {
		logic [14:0] px;
		logic [15:0] py;
		logic [14:0] pz;
		logic [15:0] nx;
		logic [14:0] ny;
		logic [15:0] nz;
		logic [31:0] col;
		logic [16:0] tu;
		logic [16:0] tv;
		logic        last;
	} vertex_t;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	logic action;
	logic signed [15:0] height_sample;
	logic vertex_valid;
	logic vertex_stall;
	logic signed [14:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [14:0] pos_z;
	logic signed [15:0] norm_x;
	logic [14:0] norm_y;
	logic signed [15:0] norm_z;
	logic [31:0] vertex_color;
	logic [16:0] tex_u;
	logic [16:0] tex_v;
	logic last_vertex;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	// Mirror of the block's state and registers.
	logic [15:0] line_prev [SEG_MAX+1];
	logic [15:0] line_old [SEG_MAX+1];
	int unsigned col_cnt, row_cnt, flush_col;
	int unsigned seg_reg, scale_reg, sizex_reg, sizez_reg;

	vertex_t pending_vertices[$];
	int fail_count = 0;
	int items_sent = 0;
	bit idle_on = 1;
	int hold_cycles = 0;
	bit hold_req = 0;

	heightmap_terrain_vertex_gen_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.action(action), .height_sample(height_sample),
		.vertex_valid(vertex_valid), .vertex_stall(vertex_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.vertex_color(vertex_color), .tex_u(tex_u), .tex_v(tex_v),
		.last_vertex(last_vertex),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint rdiv(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = (mag + den / 2) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint isqrt(longint v);
		longint res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint sx(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic int unsigned eff_segs();
		if (seg_reg < 8) return 8;
		if (seg_reg > SEG_MAX) return SEG_MAX;
		return seg_reg;
	endfunction

	function automatic longint world(longint idx, longint size, longint segs);
		return clampl(rdiv(2 * idx * size - segs * size, 2 * segs), -16000, 16000);
	endfunction

	task automatic expect_vertex(longint c, longint r, longint segs, longint h, longint hl,
			longint hr, longint hd, longint hu);
		vertex_t v;
		longint sc, dx, dz, len, n;
		sc = scale_reg;
		dx = rdiv((hl - hr) * sc, 1024);
		dz = rdiv((hd - hu) * sc, 1024);
		len = isqrt(dx * dx + 8192 * 8192 + dz * dz);
		n = clampl(h + 4096, 0, 8192);
		v.px = 15'(world(c, sizex_reg, segs));
		v.py = 16'(clampl(rdiv(h * sc, 65536), -25600, 25600));
		v.pz = 15'(world(r, sizez_reg, segs));
		v.nx = 16'(rdiv(dx * 16384, len));
		v.ny = 15'(rdiv(8192 * 16384, len));
		v.nz = 16'(rdiv(dz * 16384, len));
		v.col = 32'(32'hff000000 | ((30 + n * 50 / 8192) << 16) | ((100 + n * 100 / 8192) << 8)
			| (50 + n * 150 / 8192));
		v.tu = 17'((c * 65536 + segs / 2) / segs);
		v.tv = 17'((r * 65536 + segs / 2) / segs);
		v.last = (c == segs && r == segs);
		pending_vertices.insert(pending_vertices.size(), v);
	endtask

	// Advances the mirror by one accepted request.
	task automatic mesh_predict(bit act, logic [15:0] hs);
		int unsigned segs, c;
		longint hl, hr, hd;
		segs = eff_segs();
		if (!act) begin
			if (row_cnt > segs) return;
			c = col_cnt;
			if (row_cnt >= 1) begin
				hl = (c >= 1) ? sx(line_old[c-1]) : 0;
				hr = (c < segs) ? sx(line_prev[c+1]) : 0;
				hd = (row_cnt >= 2) ? sx(line_old[c]) : 0;
				expect_vertex(c, row_cnt - 1, segs, sx(line_prev[c]), hl, hr, hd, sx(hs));
			end
			line_old[c] = line_prev[c];
			line_prev[c] = hs;
			if (col_cnt >= segs) begin
				col_cnt = 0;
				row_cnt++;
			end else begin
				col_cnt++;
			end
		end else begin
			if (row_cnt <= segs) return;
			c = flush_col;
			hl = (c >= 1) ? sx(line_old[c-1]) : 0;
			hr = (c < segs) ? sx(line_prev[c+1]) : 0;
			expect_vertex(c, segs, segs, sx(line_prev[c]), hl, hr, sx(line_old[c]), 0);
			line_old[c] = line_prev[c];
			if (flush_col >= segs) begin
				col_cnt = 0;
				row_cnt = 0;
				flush_col = 0;
			end else begin
				flush_col++;
			end
		end
	endtask

	// Called at a falling edge; returns at a falling edge.
	task automatic send_item(bit act, logic [15:0] hs);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			sample_valid = 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		sample_valid = 1;
		action = act;
		height_sample = hs;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		mesh_predict(act, hs);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_GRID: begin
				seg_reg = data[8:0];
				col_cnt = 0;
				row_cnt = 0;
				flush_col = 0;
			end
			REG_HSCALE: scale_reg = data;
			REG_SIZE_X: sizex_reg = data[14:0];
			REG_SIZE_Z: sizez_reg = data[14:0];
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// Lets every request drain, plus the time one vertex takes in the back end.
	task automatic wait_drained();
		sample_valid = 0;
		while (pending_vertices.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_height();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3, 4: return 16'($urandom_range(0, 12288) - 6144);
			default: return 16'($urandom);
		endcase
	endfunction

	// One grid of the current size; noise adds flushes too early and samples too late.
	task automatic run_grid(bit noise);
		int unsigned segs;
		segs = eff_segs();
		for (int i = 0; i < (segs + 1) * (segs + 1); i++) begin
			if (noise && $urandom_range(0, 15) == 0) send_item(1, 16'($urandom));
			send_item(0, pick_height());
		end
		if (noise) repeat ($urandom_range(0, 3)) send_item(0, 16'($urandom));
		for (int i = 0; i <= segs; i++) send_item(1, 16'($urandom));
	endtask

	task automatic test_reset_values();
		// Two rows at the default 64 segments; a later grid write restarts the grid.
		for (int i = 0; i < 2 * 65; i++) send_item(0, pick_height());
		wait_drained();
	endtask

	task automatic test_extremes();
		write_reg(REG_GRID, 16'd8);
		write_reg(REG_HSCALE, 16'd51200);
		write_reg(REG_SIZE_X, 16'd32000);
		write_reg(REG_SIZE_Z, 16'd3200);
		send_item(1, 16'h0000);
		for (int i = 0; i < 81; i++)
			send_item(0, (i % 3 == 0) ? 16'h8000 : ((i % 3 == 1) ? 16'h7fff : 16'h0000));
		send_item(0, 16'h1234);
		for (int i = 0; i < 9; i++) send_item(1, 16'hffff);
		wait_drained();
		write_reg(REG_HSCALE, 16'd0);
		write_reg(REG_SIZE_X, 16'd3200);
		write_reg(REG_SIZE_Z, 16'd32000);
		run_grid(0);
		wait_drained();
		write_reg(REG_HSCALE, 16'd1024);
		write_reg(REG_GRID, 16'd0);
		run_grid(1);
		wait_drained();
	endtask

	task automatic test_large_grid();
		// Segment count above the maximum is clamped; two rows, restarted by a later grid write.
		write_reg(REG_GRID, 16'h01ff);
		for (int i = 0; i < 2 * (SEG_MAX + 1); i++) send_item(0, pick_height());
		wait_drained();
	endtask

	task automatic test_random_grids();
		while (items_sent < 1150) begin
			write_reg(REG_HSCALE, 16'(($urandom_range(0, 3) == 0) ? $urandom
				: $urandom_range(1024, 51200)));
			write_reg(REG_SIZE_X, 16'(($urandom_range(0, 3) == 0) ? $urandom
				: $urandom_range(3200, 32000)));
			write_reg(REG_SIZE_Z, 16'(($urandom_range(0, 3) == 0) ? $urandom
				: $urandom_range(3200, 32000)));
			write_reg(REG_GRID, 16'(($urandom_range(0, 7) == 0) ? $urandom_range(12, 16)
				: $urandom_range(0, 10)));
			run_grid(1);
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		write_reg(REG_GRID, 16'd8);
		hold_req = 1;
		run_grid(0);
		wait_drained();
	endtask

	task automatic test_no_idle();
		idle_on = 0;
		write_reg(REG_GRID, 16'd9);
		run_grid(0);
		wait_drained();
	endtask

	// Receiver: random stall bursts, and a long hold-off when asked.
	initial begin
		int burst;
		burst = 0;
		vertex_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_cycles = 3000;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				vertex_stall = 1;
			end else if (burst > 0) begin
				burst--;
				vertex_stall = 1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 5);
				vertex_stall = 1;
			end else begin
				vertex_stall = 0;
			end
		end
	end

	task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && vertex_valid && !vertex_stall) begin
			if (pending_vertices.size() == 0) begin
				$display("%0t: vertex with no request waiting, expected none, actual %0h",
					$time, pos_x);
				fail_count++;
			end else begin
				e = pending_vertices.pop_front();
				// Signed ports are compared as raw bits of their own width.
				cmp_field("pos_x", e.px, $unsigned(pos_x));
				cmp_field("pos_y", e.py, $unsigned(pos_y));
				cmp_field("pos_z", e.pz, $unsigned(pos_z));
				cmp_field("norm_x", e.nx, $unsigned(norm_x));
				cmp_field("norm_y", e.ny, norm_y);
				cmp_field("norm_z", e.nz, $unsigned(norm_z));
				cmp_field("vertex_color", e.col, vertex_color);
				cmp_field("tex_u", e.tu, tex_u);
				cmp_field("tex_v", e.tv, tex_v);
				cmp_field("last_vertex", e.last, last_vertex);
			end
		end
	end

	initial begin
		for (int i = 0; i <= SEG_MAX; i++) begin
			line_prev[i] = 0;
			line_old[i] = 0;
		end
		col_cnt = 0;
		row_cnt = 0;
		flush_col = 0;
		seg_reg = 64;
		scale_reg = 8192;
		sizex_reg = 12800;
		sizez_reg = 12800;
		arst_n = 0;
		sample_valid = 0;
		action = 0;
		height_sample = 0;
		cfg_valid = 0;
		cfg_index = REG_GRID;
		cfg_data = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);
		test_reset_values();
		test_extremes();
		test_large_grid();
		test_random_grids();
		test_backpressure();
		test_no_idle();
		if (pending_vertices.size() != 0) begin
			$display("%0t: expected %0d more vertices, actual 0", $time,
				pending_vertices.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
